>>> design/gmcp_pkg.sv
// Package for the grid minimum cost path block: widths, codes and the queue entry type.
`default_nettype none
package gmcp_pkg;

	localparam int COST_W    = 16;
	localparam int SUM_W     = 32;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int LIMIT_W   = 17;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = 2;
	localparam int Q_CNT_W   = 3;

	localparam int DEF_MAX_COLS = 512;
	localparam int DEF_MAX_ROWS = 512;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7fff_ffff;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [COST_W-1:0] cost;
		logic first_col;
		logic first_row;
		logic last_cell;
	} cell_req_t;

endpackage
`default_nettype wire

>>> design/gmcp_front.sv
// Front end: configuration registers, grid position counters and request classification.
`default_nettype none
module gmcp_front #(
	parameter int MAX_COLS = gmcp_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = gmcp_pkg::DEF_MAX_ROWS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [gmcp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [gmcp_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic                                   accept,
	input  wire logic signed [gmcp_pkg::COST_W-1:0]     cell_cost,
	output gmcp_pkg::cell_req_t                         req
);
	import gmcp_pkg::*;

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [CFG_W-1:0]   grid_rows_q;
	logic [CFG_W-1:0]   grid_cols_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [LIMIT_W-1:0] rows_eff;
	logic [LIMIT_W-1:0] cols_eff;
	logic               last_col;
	logic               last_row;
	logic               cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		if (grid_rows_q == '0) begin
			rows_eff = LIMIT_W'(1);
		end else if (LIMIT_W'(grid_rows_q) > LIMIT_W'(MAX_ROWS)) begin
			rows_eff = LIMIT_W'(MAX_ROWS);
		end else begin
			rows_eff = LIMIT_W'(grid_rows_q);
		end
		if (grid_cols_q == '0) begin
			cols_eff = LIMIT_W'(1);
		end else if (LIMIT_W'(grid_cols_q) > LIMIT_W'(MAX_COLS)) begin
			cols_eff = LIMIT_W'(MAX_COLS);
		end else begin
			cols_eff = LIMIT_W'(grid_cols_q);
		end
	end

	assign last_col = (LIMIT_W'(col_q) + LIMIT_W'(1)) >= cols_eff;
	assign last_row = (LIMIT_W'(row_q) + LIMIT_W'(1)) >= rows_eff;

	assign req.cost      = cell_cost;
	assign req.first_col = (col_q == '0);
	assign req.first_row = (row_q == '0);
	assign req.last_cell = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= CFG_W'(1);
			grid_cols_q <= CFG_W'(1);
			col_q       <= '0;
			row_q       <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_GRID_ROWS: begin
					grid_rows_q <= cfg_data;
					col_q       <= '0;
					row_q       <= '0;
				end
				CFG_GRID_COLS: begin
					grid_cols_q <= cfg_data;
					col_q       <= '0;
					row_q       <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> design/gmcp_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none
module gmcp_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  gmcp_pkg::cell_req_t       wr_req,
	output logic                      full,
	input  wire logic                 rd_en,
	output gmcp_pkg::cell_req_t       rd_req,
	output logic                      empty
);
	import gmcp_pkg::*;

	cell_req_t          slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_wr;
	logic               do_rd;

	assign full   = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_req = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> design/gmcp_back.sv
// Back end: line buffer, best predecessor selection, saturating add and result register.
`default_nettype none
module gmcp_back #(
	parameter int MAX_COLS = gmcp_pkg::DEF_MAX_COLS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  gmcp_pkg::cell_req_t                      q_req,
	input  wire logic                                q_empty,
	output logic                                     q_pop,
	input  wire logic                                pop,
	output logic                                     empty,
	output logic signed [gmcp_pkg::SUM_W-1:0]        min_path_cost
);
	import gmcp_pkg::*;

	localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [SUM_W-1:0]        line_mem [MAX_COLS];
	logic [SUM_W-1:0]        rd_data_s1;
	cell_req_t               req_s1;
	logic                    valid_s1;
	logic [COL_W-1:0]        col_s1;
	logic [COL_W-1:0]        col_next;
	logic                    fwd_sel_s1;
	logic signed [SUM_W-1:0] fwd_s1;
	logic signed [SUM_W-1:0] left_q;
	logic signed [SUM_W-1:0] diag_q;
	logic signed [SUM_W-1:0] out_q;
	logic                    out_valid_q;
	logic signed [SUM_W-1:0] up;
	logic signed [SUM_W-1:0] best;
	logic                    any;
	logic signed [SUM_W:0]   sum;
	logic signed [SUM_W-1:0] val;
	logic                    fire;
	logic                    out_take;

	assign out_take      = pop && out_valid_q;
	assign empty         = !out_valid_q;
	assign min_path_cost = out_q;

	assign fire     = valid_s1 && (!req_s1.last_cell || !out_valid_q || out_take);
	assign q_pop    = !q_empty && (!valid_s1 || fire);
	assign col_next = q_req.first_col ? '0 : col_s1 + COL_W'(1);

	always_comb begin
		up   = fwd_sel_s1 ? fwd_s1 : $signed(rd_data_s1);
		best = '0;
		any  = 1'b0;
		if (!req_s1.first_row) begin
			best = up;
			any  = 1'b1;
		end
		if (!req_s1.first_col && (!any || left_q < best)) begin
			best = left_q;
			any  = 1'b1;
		end
		if (!req_s1.first_col && !req_s1.first_row && diag_q < best) begin
			best = diag_q;
		end
		sum = (SUM_W+1)'(req_s1.cost) + (SUM_W+1)'(best);
		if (sum[SUM_W] != sum[SUM_W-1]) begin
			val = sum[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			val = sum[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_data_s1 <= line_mem[col_next];
			req_s1     <= q_req;
			fwd_s1     <= val;
		end
		if (fire) begin
			line_mem[col_s1] <= val;
			left_q           <= val;
			diag_q           <= up;
		end
		if (fire && req_s1.last_cell) begin
			out_q <= val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			col_s1      <= '0;
			fwd_sel_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1   <= 1'b1;
				col_s1     <= col_next;
				fwd_sel_s1 <= fire && (col_next == col_s1);
			end else if (fire) begin
				valid_s1   <= 1'b0;
				fwd_sel_s1 <= 1'b0;
			end
			if (fire && req_s1.last_cell) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_fwd_needs_stage : assert property (@(posedge clk) disable iff (!arst_n)
		fwd_sel_s1 |-> valid_s1)
		else $error("forwarding selected with no request in the compute stage");

	a_pop_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	a_last_gives_result : assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req_s1.last_cell) |=> !empty)
		else $error("last cell finished without a waiting result");

	a_first_col_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_req.first_col) |=> (col_s1 == '0))
		else $error("row start did not reset the column");
`endif

endmodule
`default_nettype wire

>>> design/grid_min_cost_path.sv
// Top level of the grid minimum cost path block.
//
// Channel   Direction  Handshake              Payload
// cell      in         push / full            cell_cost
// result    out        pop / empty            min_path_cost
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One grid cell is taken per cycle while the queue is not full; the line buffer read is registered
// into the compute stage and the compare-add into the result register, where the result then waits.
// A result appears once per grid, after its bottom-right cell.
// Reset returns the position to the top-left cell; no clearing pass is needed.
// A waiting result only stalls the compute stage on the next grid's last cell;
// the four-entry request queue lets cells keep arriving meanwhile.
`default_nettype none
module grid_min_cost_path #(
	parameter int MAX_COLS = gmcp_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = gmcp_pkg::DEF_MAX_ROWS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic signed [gmcp_pkg::COST_W-1:0] cell_cost,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic signed [gmcp_pkg::SUM_W-1:0]       min_path_cost,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [gmcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gmcp_pkg::CFG_W-1:0]         cfg_data
);
	import gmcp_pkg::*;

	cell_req_t front_req;
	cell_req_t head_req;
	logic      accept;
	logic      q_empty;
	logic      q_pop;

	assign accept = push && !full;

	gmcp_front #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.cell_cost (cell_cost),
		.req       (front_req)
	);

	gmcp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_req (front_req),
		.full   (full),
		.rd_en  (q_pop),
		.rd_req (head_req),
		.empty  (q_empty)
	);

	gmcp_back #(
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_req         (head_req),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.min_path_cost (min_path_cost)
	);

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for grid_min_cost_path: directed and random grids against a path-sum predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gmcp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE0 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE1 = 2'd3;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned DRAIN_CYCLES  = 16;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned RANDOM_CELLS  = 200;

	typedef enum logic [1:0] {REQ_CELL, REQ_CFG, REQ_SETTLE, REQ_HOLD} req_kind_t;
	typedef enum logic [1:0] {COST_ANY, COST_NEAR_ZERO, COST_EXTREME} cost_mix_t;

	typedef struct packed {
		req_kind_t                  kind;
		logic signed [COST_W-1:0]   cost;
		logic [CFG_IDX_W-1:0]       idx;
		logic [CFG_W-1:0]           data;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [COST_W-1:0] cell_cost = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [SUM_W-1:0] min_path_cost;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic hold_req = 1'b0;
	int unsigned hold_left = 0;

	stim_t stim_q[$];
	logic signed [SUM_W-1:0] path_totals[$];
	int unsigned err_count = 0;

	int unsigned send_gap = 0, send_calm = 0, settle_cnt = 0;
	int unsigned recv_gap = 0, recv_calm = 0;

	int unsigned set_rows = 1, set_cols = 1;
	longint line_best[DEF_MAX_COLS];
	longint left_best = 0, diag_best = 0;
	int unsigned row_pos = 0, col_pos = 0;

	grid_min_cost_path dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cell_cost(cell_cost),
		.empty(empty),
		.pop(pop),
		.min_path_cost(min_path_cost),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned size_of(int unsigned v, int unsigned maxv);
		if (v == 0) begin
			return 1;
		end
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic void restart_path();
		left_best = 0;
		diag_best = 0;
		row_pos = 0;
		col_pos = 0;
	endfunction

	function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			CFG_GRID_ROWS: begin
				set_rows = data;
				restart_path();
			end
			CFG_GRID_COLS: begin
				set_cols = data;
				restart_path();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic bit advance_path(input logic signed [COST_W-1:0] cost,
			output logic signed [SUM_W-1:0] total);
		int unsigned rows, cols;
		longint up, best, sum;
		bit any;
		rows = size_of(set_rows, DEF_MAX_ROWS);
		cols = size_of(set_cols, DEF_MAX_COLS);
		up = (row_pos > 0) ? line_best[col_pos] : 0;
		best = 0;
		any = 1'b0;
		if (row_pos > 0) begin
			best = up;
			any = 1'b1;
		end
		if (col_pos > 0 && (!any || left_best < best)) begin
			best = left_best;
			any = 1'b1;
		end
		if (row_pos > 0 && col_pos > 0 && (!any || diag_best < best)) begin
			best = diag_best;
			any = 1'b1;
		end
		sum = any ? longint'(cost) + best : longint'(cost);
		if (sum > longint'(SUM_MAX)) begin
			sum = longint'(SUM_MAX);
		end else if (sum < longint'(SUM_MIN)) begin
			sum = longint'(SUM_MIN);
		end
		diag_best = up;
		left_best = sum;
		line_best[col_pos] = sum;
		total = sum[SUM_W-1:0];
		advance_path = 1'b0;
		if (col_pos + 1 >= cols) begin
			col_pos = 0;
			if (row_pos + 1 >= rows) begin
				restart_path();
				advance_path = 1'b1;
			end else begin
				row_pos = row_pos + 1;
				left_best = 0;
				diag_best = 0;
			end
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm != 0) begin
			calm = calm - 1;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm = $urandom_range(16, 64);
			return 0;
		end
		return $urandom_range(0, 3);
	endfunction

	function automatic logic signed [COST_W-1:0] pick_cost(cost_mix_t mix);
		case (mix)
			COST_NEAR_ZERO: return COST_W'($urandom_range(0, 40)) - COST_W'(20);
			COST_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'hffff;
					default: return 16'h0000;
				endcase
			end
			default: return COST_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int unsigned pick_dim();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			return $urandom_range(1, 6);
		end else if (r < 9) begin
			return $urandom_range(1, 24);
		end
		return 0;
	endfunction

	task automatic add_cells(int unsigned n, cost_mix_t mix);
		repeat (n) stim_q.push_back('{REQ_CELL, pick_cost(mix), '0, '0});
	endtask

	task automatic add_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		stim_q.push_back('{REQ_SETTLE, '0, '0, '0});
		stim_q.push_back('{REQ_CFG, '0, idx, data});
	endtask

	task automatic set_size(int unsigned rows, int unsigned cols);
		add_setting(CFG_GRID_ROWS, CFG_W'(rows));
		add_setting(CFG_GRID_COLS, CFG_W'(cols));
	endtask

	task automatic build_stimulus();
		int unsigned rows, cols, n, k, done;
		cost_mix_t mix;
		stim_q.push_back('{REQ_CELL, 16'sh7fff, '0, '0});
		stim_q.push_back('{REQ_CELL, 16'sh8000, '0, '0});
		stim_q.push_back('{REQ_CELL, 16'sh0000, '0, '0});
		stim_q.push_back('{REQ_CELL, 16'shffff, '0, '0});
		set_size(2, 2);
		repeat (4) stim_q.push_back('{REQ_CELL, 16'sh8000, '0, '0});
		repeat (4) stim_q.push_back('{REQ_CELL, 16'sh7fff, '0, '0});
		set_size(0, 3);
		add_cells(3, COST_EXTREME);
		set_size(3, 0);
		add_cells(3, COST_ANY);
		set_size(2, 3);
		add_cells(2, COST_ANY);
		add_setting(CFG_GRID_COLS, CFG_W'(3));
		add_cells(3, COST_NEAR_ZERO);
		add_setting(CFG_IDX_SPARE0, 10'h3ff);
		add_cells(3, COST_NEAR_ZERO);
		add_setting(CFG_IDX_SPARE1, 10'h000);
		add_cells(6, COST_EXTREME);

		set_size(1, 1023);
		add_cells(512, COST_ANY);

		set_size(1, 1);
		stim_q.push_back('{REQ_HOLD, '0, '0, '0});
		add_cells(40, COST_ANY);

		done = 0;
		while (done < RANDOM_CELLS) begin
			rows = pick_dim();
			cols = pick_dim();
			set_size(rows, cols);
			n = size_of(rows, DEF_MAX_ROWS) * size_of(cols, DEF_MAX_COLS);
			mix = cost_mix_t'($urandom_range(0, 2));
			repeat ($urandom_range(1, 4)) begin
				if (n > 1 && $urandom_range(0, 7) == 0) begin
					k = $urandom_range(1, n - 1);
					add_cells(k, mix);
					add_setting($urandom_range(0, 1) ? CFG_IDX_SPARE0 : CFG_IDX_SPARE1,
						CFG_W'($urandom_range(0, 1023)));
					add_cells(n - k, mix);
				end else begin
					add_cells(n, mix);
				end
				done += n;
				if ($urandom_range(0, 9) == 0) begin
					stim_q.push_back('{REQ_SETTLE, '0, '0, '0});
				end
			end
			if (n > 1 && $urandom_range(0, 5) == 0) begin
				k = $urandom_range(1, n - 1);
				add_cells(k, mix);
				done += k;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stim_t head;
		logic push_n, cfg_valid_n, hold_n;
		logic signed [SUM_W-1:0] total;
		if (!arst_n) begin
			push <= 1'b0;
			cfg_valid <= 1'b0;
			hold_req <= 1'b0;
			cell_cost <= '0;
			cfg_index <= '0;
			cfg_data <= '0;
		end else begin
			push_n = push;
			cfg_valid_n = cfg_valid;
			hold_n = 1'b0;
			if (push && !full) begin
				if (advance_path(cell_cost, total)) begin
					path_totals.push_back(total);
				end
				push_n = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				apply_setting(cfg_index, cfg_data);
				cfg_valid_n = 1'b0;
			end
			if (!push_n && !cfg_valid_n) begin
				if (send_gap != 0) begin
					send_gap = send_gap - 1;
				end else if (stim_q.size() != 0) begin
					head = stim_q[0];
					case (head.kind)
						REQ_CELL: begin
							cell_cost <= head.cost;
							push_n = 1'b1;
							void'(stim_q.pop_front());
							send_gap = draw_wait(send_calm);
						end
						REQ_CFG: begin
							cfg_index <= head.idx;
							cfg_data <= head.data;
							cfg_valid_n = 1'b1;
							void'(stim_q.pop_front());
						end
						REQ_SETTLE: begin
							if (path_totals.size() == 0) begin
								settle_cnt = settle_cnt + 1;
								if (settle_cnt >= SETTLE_CYCLES) begin
									settle_cnt = 0;
									void'(stim_q.pop_front());
								end
							end else begin
								settle_cnt = 0;
							end
						end
						default: begin
							hold_n = 1'b1;
							void'(stim_q.pop_front());
						end
					endcase
				end
			end
			push <= push_n;
			cfg_valid <= cfg_valid_n;
			hold_req <= hold_n;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		logic signed [SUM_W-1:0] want;
		logic pop_n;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			pop_n = pop;
			if (pop && !empty) begin
				if (path_totals.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result, expected none, got %0d",
						$time, min_path_cost);
				end else begin
					want = path_totals.pop_front();
					if (min_path_cost !== want) begin
						err_count++;
						$display("%0t: min_path_cost mismatch, expected %0d, got %0d",
							$time, want, min_path_cost);
					end
				end
				pop_n = 1'b0;
				recv_gap = draw_wait(recv_calm);
			end
			if (hold_left != 0) begin
				pop_n = 1'b0;
			end else if (!pop_n) begin
				if (recv_gap != 0) begin
					recv_gap = recv_gap - 1;
				end else begin
					pop_n = 1'b1;
				end
			end
			pop <= pop_n;
		end
	end

	initial begin
		build_stimulus();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (stim_q.size() != 0 || push || cfg_valid) @(posedge clk);
		while (path_totals.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && path_totals.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
design/gmcp_pkg.sv
design/gmcp_front.sv
design/gmcp_queue.sv
design/gmcp_back.sv
design/grid_min_cost_path.sv
verif/tb_top.sv
